### sv/scu_pkg.sv
`timescale 1ns / 1ps

package scu_pkg;

  localparam int SIG_BYTES  = 16;
  localparam int SIG_IDX_W  = 4;
  localparam int LEN_W      = 5;
  localparam int OUT_OFS_W  = 48;
  localparam int COUNT_W    = 32;
  localparam int SCOPE_W    = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Result buffer geometry
  localparam int RB_DEPTH = 4;
  localparam int RB_PTR_W = 2;
  localparam int RB_CNT_W = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SIG_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

  // Register reset values
  localparam logic [LEN_W-1:0]   SIG_LEN_RESET = 5'd1;
  localparam logic [COUNT_W-1:0] SKIP_RESET    = 32'd0;
  localparam logic [COUNT_W-1:0] LIMIT_RESET   = 32'hFFFF_FFFF;

  // Scope counter after reset: skip scope reset value plus one
  localparam logic [SCOPE_W-1:0] SCOPE_RESET = 33'd1;

  typedef enum logic {
    EV_NEW = 1'b0,
    EV_END = 1'b1
  } event_kind_t;

  typedef struct packed {
    event_kind_t            kind;
    logic [OUT_OFS_W-1:0]   item_offset;
    logic [OUT_OFS_W-1:0]   closed_size;
    logic                   closed_valid;
    logic [COUNT_W-1:0]     item_number;
    logic                   limit_reached;
    logic                   last_result;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] skip;
    logic [COUNT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic               fire;
    logic               last;
    logic               have_item;
    logic               stopped;
    logic [COUNT_W-1:0] found_count;
  } core_stat_t;

endpackage

### sv/scu_cfg.sv
`timescale 1ns / 1ps

module scu_cfg #(
  parameter int SIGN_MAX = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [scu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output scu_pkg::cfg_t                    cfg,
  output logic [SIGN_MAX-1:0][7:0]         sig_align,
  output logic [SIGN_MAX-1:0]              sig_mask
);
  import scu_pkg::*;

  logic [63:0]                 sig_low;
  logic [63:0]                 sig_high;
  logic [LEN_W-1:0]            sig_length;
  logic [COUNT_W-1:0]          skip;
  logic [COUNT_W-1:0]          limit;
  logic [LEN_W-1:0]            len_eff;
  logic [LEN_W-1:0]            len;
  logic [SIG_BYTES-1:0][7:0]   sig_all;
  logic [SIGN_MAX-1:0][7:0]    align_next;
  logic [SIGN_MAX-1:0]         mask_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_low    <= '0;
      sig_high   <= '0;
      sig_length <= SIG_LEN_RESET;
      skip       <= SKIP_RESET;
      limit      <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIG_LOW:  sig_low    <= cfg_data[63:0];
        REG_SIG_HIGH: sig_high   <= cfg_data[63:0];
        REG_SIG_LEN:  sig_length <= cfg_data[LEN_W-1:0];
        REG_SKIP:     skip       <= cfg_data[COUNT_W-1:0];
        REG_LIMIT:    limit      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length into 1..SIGN_MAX
  always_comb begin
    len_eff = sig_length;
    if (sig_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (sig_length > LEN_W'(SIGN_MAX)) begin
      len_eff = LEN_W'(SIGN_MAX);
    end
  end

  assign sig_all = {sig_high, sig_low};

  // Window slot j (0 = newest) holds signature byte len-1-j
  always_comb begin
    logic [LEN_W-1:0] pos;
    pos = '0;
    for (int j = 0; j < SIGN_MAX; j++) begin
      pos           = len_eff - LEN_W'(1) - LEN_W'(j);
      align_next[j] = sig_all[pos[SIG_IDX_W-1:0]];
      mask_next[j]  = LEN_W'(j) < len_eff;
    end
  end

  always_ff @(posedge clk) begin
    sig_align <= align_next;
    sig_mask  <= mask_next;
    len       <= len_eff;
  end

  assign cfg.len   = len;
  assign cfg.skip  = skip;
  assign cfg.limit = limit;

endmodule

### sv/scu_core.sv
`timescale 1ns / 1ps

module scu_core #(
  parameter int SIGN_MAX    = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  input  scu_pkg::cfg_t               cfg,
  input  logic [SIGN_MAX-1:0][7:0]    sig_align,
  input  logic [SIGN_MAX-1:0]         sig_mask,
  input  logic                        room,
  output logic [1:0]                  push,
  output scu_pkg::result_t            res0,
  output scu_pkg::result_t            res1,
  output scu_pkg::core_stat_t         stat
);
  import scu_pkg::*;

  // Input register
  logic                         in_full;
  logic [7:0]                   in_byte;
  logic                         in_last;

  // Scan state
  logic [SIGN_MAX-1:0][7:0]     window;
  logic [OFFSET_BITS-1:0]       stream_offset;
  logic [OFFSET_BITS-1:0]       last_item_start;
  logic [OFFSET_BITS-1:0]       block_until;
  logic                         have_item;
  logic                         stopped;
  logic [COUNT_W-1:0]           found_count;
  logic [SCOPE_W-1:0]           scope_counter;

  logic                         fire;
  logic [SIGN_MAX-1:0][7:0]     win_new;
  logic [SIGN_MAX-1:0]          hit_vec;
  logic                         match;
  logic [OFFSET_BITS-1:0]       len_ext;
  logic [OFFSET_BITS-1:0]       len_m1;
  logic [OFFSET_BITS-1:0]       q;
  logic [OFFSET_BITS-1:0]       n1;
  logic                         examine;
  logic                         pos_open;
  logic                         scope_ok;
  logic                         accept;
  logic [COUNT_W-1:0]           found_inc;
  logic                         stop_new;
  logic                         have_a;
  logic [OFFSET_BITS-1:0]       lis_a;
  logic [COUNT_W-1:0]           cnt_a;
  result_t                      new_res;
  result_t                      end_res;

  assign fire     = in_full && room;
  assign in_ready = !in_full || fire;

  always_comb begin
    win_new[0] = in_byte;
    for (int j = 1; j < SIGN_MAX; j++) begin
      win_new[j] = window[j-1];
    end
    for (int j = 0; j < SIGN_MAX; j++) begin
      hit_vec[j] = !sig_mask[j] || (win_new[j] == sig_align[j]);
    end
  end

  assign match   = &hit_vec;
  assign len_ext = OFFSET_BITS'(cfg.len);
  assign len_m1  = len_ext - OFFSET_BITS'(1);
  assign examine = !stopped && (stream_offset >= len_m1);
  assign q       = stream_offset - len_m1;
  assign pos_open = q >= block_until;
  assign scope_ok = !have_item || (scope_counter >= {1'b0, cfg.skip});
  assign accept   = examine && pos_open && match && scope_ok;

  assign found_inc = found_count + COUNT_W'(1);
  assign stop_new  = stopped || (accept && (found_inc >= cfg.limit));
  assign n1        = stream_offset + OFFSET_BITS'(1);
  assign have_a    = have_item || accept;
  assign lis_a     = accept ? q : last_item_start;
  assign cnt_a     = accept ? found_inc : found_count;

  always_comb begin
    new_res.kind          = EV_NEW;
    new_res.item_offset   = OUT_OFS_W'(q);
    new_res.closed_size   = have_item ? OUT_OFS_W'(q - last_item_start) : '0;
    new_res.closed_valid  = have_item;
    new_res.item_number   = found_inc;
    new_res.limit_reached = stop_new;
    new_res.last_result   = !in_last;

    end_res.kind          = EV_END;
    end_res.item_offset   = OUT_OFS_W'(n1);
    end_res.closed_size   = have_a ? OUT_OFS_W'(n1 - lis_a) : '0;
    end_res.closed_valid  = have_a;
    end_res.item_number   = cnt_a;
    end_res.limit_reached = stop_new;
    end_res.last_result   = 1'b1;
  end

  // New item goes first; the end event follows in the same push
  assign res0 = accept ? new_res : end_res;
  assign res1 = end_res;
  assign push = fire ? {accept && in_last, accept ^ in_last} : 2'b00;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window          <= '0;
      stream_offset   <= '0;
      last_item_start <= '0;
      block_until     <= '0;
      have_item       <= 1'b0;
      stopped         <= 1'b0;
      found_count     <= '0;
      scope_counter   <= SCOPE_RESET;
    end else if (fire) begin
      if (in_last) begin
        // end of stream: back to a fresh stream
        window          <= '0;
        stream_offset   <= '0;
        last_item_start <= '0;
        block_until     <= '0;
        have_item       <= 1'b0;
        stopped         <= 1'b0;
        found_count     <= '0;
        scope_counter   <= {1'b0, cfg.skip} + SCOPE_W'(1);
      end else begin
        window        <= win_new;
        stream_offset <= n1;
        stopped       <= stop_new;
        if (accept) begin
          found_count     <= found_inc;
          have_item       <= 1'b1;
          last_item_start <= q;
          scope_counter   <= '0;
          block_until     <= q + len_ext;
        end else if (examine && pos_open && (scope_counter != '1)) begin
          scope_counter <= scope_counter + SCOPE_W'(1);
        end
      end
    end
  end

  assign stat.fire        = fire;
  assign stat.last        = in_last;
  assign stat.have_item   = have_item;
  assign stat.stopped     = stopped;
  assign stat.found_count = found_count;

endmodule

### sv/scu_rbuf.sv
`timescale 1ns / 1ps

module scu_rbuf (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push,
  input  scu_pkg::result_t              res0,
  input  scu_pkg::result_t              res1,
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scu_pkg::result_t              out_res,
  output logic [scu_pkg::RB_CNT_W-1:0]  count
);
  import scu_pkg::*;

  result_t               slots [RB_DEPTH];
  logic [RB_PTR_W-1:0]   wptr;
  logic [RB_PTR_W-1:0]   rptr;
  logic                  pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_res   = slots[rptr];
  assign room      = count <= RB_CNT_W'(RB_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push != 2'b00) begin
      slots[wptr] <= res0;
    end
    if (push == 2'd2) begin
      slots[wptr + RB_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + RB_PTR_W'(push);
      rptr  <= rptr + RB_PTR_W'(pop);
      count <= count + RB_CNT_W'(push) - RB_CNT_W'(pop);
    end
  end

endmodule

### sv/signature_carving_scanner_unit.sv
`timescale 1ns / 1ps

// Signature carving scanner. Feed the stream one byte per transaction on the
// input channel, with last_byte set on its final byte. The block keeps the
// newest SIGN_MAX bytes and reports each non-overlapping occurrence of the
// configured signature (up to 16 bytes) as a new-item result carrying its
// start offset and the size of the item it closes; the final byte adds an
// end-of-stream result that closes the last item against the stream length
// and returns the scanner to a fresh stream. A match is taken only once
// skip_scope examined start positions have passed since the end of the last
// accepted signature, and new items stop once item_limit is reached.
// Rate: one byte per clock while the result buffer has room. A byte is held
// in an input register, then the window compare, offset compares and counter
// updates run combinationally and drop zero, one or two results into a
// four-entry result buffer; the first result reaches the output through the
// input register and then the result buffer. The output port moves one
// result per cycle while out_ready is high, so a byte that yields two results
// occupies the output port for both and sustained throughput follows it.
// Write configuration only while the block is idle. There is no clearing
// pass after reset.
module signature_carving_scanner_unit #(
  parameter int SIGN_MAX    = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scu_pkg::CFG_DATA_W-1:0]    cfg_data,
  // byte stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        data_byte,
  input  logic                              last_byte,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              event_kind,
  output logic [scu_pkg::OUT_OFS_W-1:0]     item_offset,
  output logic [scu_pkg::OUT_OFS_W-1:0]     closed_size,
  output logic                              closed_valid,
  output logic [scu_pkg::COUNT_W-1:0]       item_number,
  output logic                              limit_reached,
  output logic                              last_result
);
  import scu_pkg::*;

  cfg_t                       cfg;
  logic [SIGN_MAX-1:0][7:0]   sig_align;
  logic [SIGN_MAX-1:0]        sig_mask;
  logic                       room;
  logic [1:0]                 push;
  result_t                    res0;
  result_t                    res1;
  result_t                    out_res;
  core_stat_t                 core_stat;
  logic [RB_CNT_W-1:0]        rb_count;

  // Register writes are always accepted
  assign cfg_ready = 1'b1;

  scu_cfg #(
    .SIGN_MAX (SIGN_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .sig_align (sig_align),
    .sig_mask  (sig_mask)
  );

  // Input register, window compare and scan state
  scu_core #(
    .SIGN_MAX    (SIGN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg       (cfg),
    .sig_align (sig_align),
    .sig_mask  (sig_mask),
    .room      (room),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .stat      (core_stat)
  );

  // Result buffer decouples the scan from output back-pressure
  scu_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .count     (rb_count)
  );

  assign event_kind    = out_res.kind;
  assign item_offset   = out_res.item_offset;
  assign closed_size   = out_res.closed_size;
  assign closed_valid  = out_res.closed_valid;
  assign item_number   = out_res.item_number;
  assign limit_reached = out_res.limit_reached;
  assign last_result   = out_res.last_result;

  // Result buffer never overflows
  a_rbuf_bound: assert property (@(posedge clk) disable iff (rst)
    rb_count <= RB_CNT_W'(RB_DEPTH))
    else $error("result buffer overflow");

  // End of stream returns the scan state to a fresh stream
  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    core_stat.fire && core_stat.last |=>
      core_stat.found_count == '0 && !core_stat.have_item && !core_stat.stopped)
    else $error("scan state not cleared after end of stream");

  // Once stopped, stay stopped until the stream ends
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    core_stat.stopped && !(core_stat.fire && core_stat.last) |=> core_stat.stopped)
    else $error("item limit stop released inside a stream");

  // Item count moves only when a byte is processed
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !core_stat.fire |=> $stable(core_stat.found_count))
    else $error("item count changed without a processed byte");

endmodule

### tb/signature_carving_scanner_unit_test.sv
`timescale 1ns / 1ps

module signature_carving_scanner_unit_test;
  import scu_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 4;
  localparam int DRAIN_CYCLES   = 6;    // input register plus compare stage, with margin
  localparam int HOLD_CYCLES    = 120;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000; // cycles without any transaction
  localparam int REPORT_CAP     = 200;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [COUNT_W-1:0]   LIMIT_MAX  = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0]   SKIP_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_RHYTHM
  } rx_mode_t;

  // DUT connections; every input starts at a known value
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  event_kind;
  logic [OUT_OFS_W-1:0]  item_offset;
  logic [OUT_OFS_W-1:0]  closed_size;
  logic                  closed_valid;
  logic [COUNT_W-1:0]    item_number;
  logic                  limit_reached;
  logic                  last_result;

  // Register mirror
  logic [63:0]        sig_lo_cfg;
  logic [63:0]        sig_hi_cfg;
  logic [LEN_W-1:0]   sig_len_cfg;
  logic [COUNT_W-1:0] skip_cfg;
  logic [COUNT_W-1:0] limit_cfg;

  // Scanner state mirror
  logic [7:0]           win [SIG_BYTES];
  logic [OUT_OFS_W-1:0] stream_pos;
  logic [OUT_OFS_W-1:0] item_start;
  bit                   have_item;
  logic [COUNT_W-1:0]   found_count;
  logic [SCOPE_W-1:0]   scope_count;
  logic [OUT_OFS_W-1:0] next_start;
  bit                   scan_stopped;

  // Events the scanner still owes us, oldest first
  result_t pending_events[$];

  int errors = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  signature_carving_scanner_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .item_offset  (item_offset),
    .closed_size  (closed_size),
    .closed_valid (closed_valid),
    .item_number  (item_number),
    .limit_reached(limit_reached),
    .last_result  (last_result)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scanner prediction
  // ---------------------------------------------------------------------------

  // Effective signature length: zero acts as one, anything above the window
  // size is clamped to the window size.
  function automatic int unsigned eff_len();
    if (sig_len_cfg == 0) return 1;
    if (sig_len_cfg > SIG_BYTES) return SIG_BYTES;
    return int'(sig_len_cfg);
  endfunction

  function automatic logic [7:0] sig_byte(input int unsigned idx);
    if (idx < 8) return sig_lo_cfg[8*idx +: 8];
    return sig_hi_cfg[8*(idx-8) +: 8];
  endfunction

  // Return the stream state to a fresh stream; registers are kept.
  task automatic clear_stream();
    foreach (win[k]) win[k] = 8'h00;
    stream_pos   = '0;
    item_start   = '0;
    have_item    = 1'b0;
    found_count  = '0;
    scope_count  = {1'b0, skip_cfg} + 1'b1;
    next_start   = '0;
    scan_stopped = 1'b0;
  endtask

  // Queue one event; the closed size refers to the item open before this event.
  task automatic push_event(input event_kind_t kind, input logic [OUT_OFS_W-1:0] ofs);
    result_t r;
    r.kind          = kind;
    r.item_offset   = ofs;
    r.closed_size   = have_item ? ofs - item_start : '0;
    r.closed_valid  = have_item;
    r.item_number   = found_count;
    r.limit_reached = scan_stopped;
    r.last_result   = 1'b0;
    pending_events.push_back(r);
  endtask

  // Advance the scanner by one accepted byte and queue what it reports.
  task automatic scan_byte(input logic [7:0] b, input logic fin);
    int unsigned          len;
    logic [OUT_OFS_W-1:0] n;
    logic [OUT_OFS_W-1:0] q;
    bit                   hit;
    int                   count;
    len   = eff_len();
    n     = stream_pos;
    count = 0;
    for (int k = SIG_BYTES - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    // Examine the start position whose last signature byte just arrived,
    // unless it lies inside the last accepted signature.
    if (!scan_stopped && n >= len - 1) begin
      q = n - (len - 1);
      if (q >= next_start) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (win[len-1-k] != sig_byte(k)) hit = 1'b0;
        end
        if (hit && (!have_item || scope_count >= {1'b0, skip_cfg})) begin
          found_count = found_count + 1'b1;
          if (found_count >= limit_cfg) scan_stopped = 1'b1;
          push_event(EV_NEW, q);
          count++;
          have_item   = 1'b1;
          item_start  = q;
          scope_count = '0;
          next_start  = q + len;
        end else if (scope_count != {SCOPE_W{1'b1}}) begin
          scope_count = scope_count + 1'b1;
        end
      end
    end
    stream_pos = n + 1'b1;
    if (fin) begin
      push_event(EV_END, stream_pos);
      count++;
      clear_stream();
    end
    if (count > 0) pending_events[$].last_result = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one register; mirror it at the accepting edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SIG_LOW:  sig_lo_cfg  = data;
      REG_SIG_HIGH: sig_hi_cfg  = data;
      REG_SIG_LEN:  sig_len_cfg = data[LEN_W-1:0];
      REG_SKIP:     skip_cfg    = data[COUNT_W-1:0];
      REG_LIMIT:    limit_cfg   = data[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Write all five registers; fill unused upper data bits with noise.
  task automatic configure_scan(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [LEN_W-1:0] len, input logic [COUNT_W-1:0] skip,
                                input logic [COUNT_W-1:0] limit);
    logic [CFG_DATA_W-1:0] noise;
    write_reg(REG_SIG_LOW, lo);
    write_reg(REG_SIG_HIGH, hi);
    noise = {$urandom, $urandom};
    write_reg(REG_SIG_LEN, {noise[63:LEN_W], len});
    noise = {$urandom, $urandom};
    write_reg(REG_SKIP, {noise[63:32], skip});
    noise = {$urandom, $urandom};
    write_reg(REG_LIMIT, {noise[63:32], limit});
  endtask

  // Offer one byte; bursts of random length, random gaps between them while gaps_on is set.
  // Valid stays high across a burst, so it is never dropped and raised in
  // the same step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  = 1'b1;
    data_byte = b;
    last_byte = fin;
    do @(posedge clk); while (!in_ready);
    scan_byte(b, fin);
  endtask

  // Wait until the block is idle: nothing owed, and the last byte has
  // cleared the pipeline even if it caused no event.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Send one stream of nbytes: mostly signature copies, broken prefixes and
  // near-miss bytes, with some plain noise. Truncation may cut a copy short.
  task automatic send_stream(input int unsigned nbytes, input int unsigned plant_pct);
    logic [7:0]  stream_data[$];
    int unsigned len;
    int unsigned cut;
    int unsigned pick;
    len = eff_len();
    while (stream_data.size() < nbytes) begin
      pick = $urandom_range(0, 99);
      if (pick < plant_pct) begin
        for (int k = 0; k < len; k++) stream_data.push_back(sig_byte(k));
      end else if (pick < plant_pct + 15) begin
        cut = $urandom_range(1, len);
        for (int k = 0; k < cut; k++) stream_data.push_back(sig_byte(k));
      end else if (pick < plant_pct + 55) begin
        stream_data.push_back(sig_byte($urandom_range(0, len - 1)));
      end else begin
        stream_data.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < nbytes; i++) send_byte(stream_data[i], i == nbytes - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       beat;
    mode      = RX_OPEN;
    mode_left = 0;
    beat      = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // Hold results back long enough that the block fills and stalls input.
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        beat++;
        case (mode)
          RX_OPEN:   out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
          RX_RHYTHM: out_ready = (beat % 5) < 3;
          default:   out_ready = 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < REPORT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result, item_offset", item_offset, '0);
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind)
          report_mismatch("event_kind", event_kind, want.kind);
        if (item_offset !== want.item_offset)
          report_mismatch("item_offset", item_offset, want.item_offset);
        if (closed_size !== want.closed_size)
          report_mismatch("closed_size", closed_size, want.closed_size);
        if (closed_valid !== want.closed_valid)
          report_mismatch("closed_valid", closed_valid, want.closed_valid);
        if (item_number !== want.item_number)
          report_mismatch("item_number", item_number, want.item_number);
        if (limit_reached !== want.limit_reached)
          report_mismatch("limit_reached", limit_reached, want.limit_reached);
        if (last_result !== want.last_result)
          report_mismatch("last_result", last_result, want.last_result);
      end
    end
  end

  // Watchdog: end the run when no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: single-byte signature 0x00, no skip, no limit.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Streams that end before a full signature fits give only the end event.
  task automatic test_short_stream();
    drain_pipeline();
    configure_scan({$urandom, $urandom}, {$urandom, $urandom}, 5'd4, 32'd0, LIMIT_MAX);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Length zero acts as one; an unused register index is ignored.
  task automatic test_length_clamp();
    drain_pipeline();
    configure_scan(64'hC3, 64'h0, 5'd0, 32'd0, LIMIT_MAX);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  // Skip scope of one: a match right after an accepted signature is passed
  // over, the next one is taken.
  task automatic test_skip_scope();
    drain_pipeline();
    configure_scan(64'hB2A1, 64'h0, 5'd2, 32'd1, LIMIT_MAX);
    for (int i = 0; i < 3; i++) begin
      send_byte(8'hA1, 1'b0);
      send_byte(8'hB2, i == 2);
    end
  endtask

  // Limit zero stops after the first item; a limit lowered below the count
  // in mid-stream stops at the next acceptance.
  task automatic test_item_limit();
    drain_pipeline();
    configure_scan(64'h5A, 64'h0, 5'd1, 32'd0, 32'd0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain_pipeline();
    write_reg(REG_LIMIT, {32'($urandom), LIMIT_MAX});
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain_pipeline();
    write_reg(REG_LIMIT, {32'($urandom), 32'd1});
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Random streams over several register settings, extremes among them.
  task automatic test_random_streams();
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] skip;
    logic [COUNT_W-1:0] limit;
    int unsigned        done;
    int unsigned        n;
    for (int p = 0; p < 7; p++) begin
      lo    = {$urandom, $urandom};
      hi    = {$urandom, $urandom};
      skip  = 32'd0;
      limit = LIMIT_MAX;
      case (p)
        0: len = 5'd1;
        1: len = 5'd16;
        2: begin
          len  = 5'd3;
          skip = $urandom_range(1, 3);
        end
        3: begin
          len   = 5'd2;
          limit = 32'd3;
        end
        4: begin
          // all-ones signature, clamped length, skip never passed
          lo   = '1;
          hi   = '1;
          len  = 5'd31;
          skip = SKIP_MAX;
        end
        5: begin
          lo   = '0;
          hi   = '0;
          len  = 5'd17;
          skip = $urandom_range(0, 2);
        end
        default: begin
          len   = 5'($urandom_range(1, 8));
          skip  = $urandom_range(0, 4);
          limit = $urandom_range(1, 6);
        end
      endcase
      drain_pipeline();
      configure_scan(lo, hi, len, skip, limit);
      done = 0;
      while (done < 60) begin
        gaps_on = ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, eff_len());
        else n = $urandom_range(1, 2 * eff_len() + 24);
        send_stream(n, 30);
        done += n;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Hold the receiver off while the sender keeps offering matching bytes,
  // so the result buffer fills and the input stalls.
  task automatic test_backpressure();
    drain_pipeline();
    configure_scan(64'h5A, {$urandom, $urandom}, 5'd1, 32'd0, LIMIT_MAX);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'h5A, i == 39);
    gaps_on = 1'b1;
  endtask

  initial begin
    sig_lo_cfg  = '0;
    sig_hi_cfg  = '0;
    sig_len_cfg = SIG_LEN_RESET;
    skip_cfg    = SKIP_RESET;
    limit_cfg   = LIMIT_RESET;
    clear_stream();

    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_short_stream();
    test_length_clamp();
    test_skip_scope();
    test_item_limit();
    test_random_streams();
    test_backpressure();

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
